@@ rtl/efa_pkg.sv @@
// ----------------------------------------------------------------------------
// efa_pkg: shared types for the extent free-list allocator
// operation and status codes, table entry layout, and the command and
// status bundles that join the controller to the datapath
// ----------------------------------------------------------------------------
`default_nettype none

package efa_pkg;

  localparam int EFA_TABLE_ENTRIES = 32;
  localparam int EFA_ADDR_W        = 32;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_TAKE  = 2'd2,
    OP_NONE  = 2'd3
  } efa_op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } efa_status_t;

  // table read address select
  typedef enum logic [2:0] {
    RD_ZERO,
    RD_LAST,
    RD_NEXT,
    RD_SKIP_UP,
    RD_SKIP_DOWN
  } efa_rd_sel_t;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_INC,
    IDX_DEC,
    IDX_COUNT
  } efa_idx_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_UPDATE,
    WR_SHIFT,
    WR_NEW
  } efa_wr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } efa_cnt_op_t;

  typedef struct packed {
    logic [EFA_ADDR_W-1:0] start;
    logic [EFA_ADDR_W-1:0] length;
  } efa_entry_t;

  typedef struct packed {
    logic        start;
    efa_rd_sel_t rd_sel;
    efa_idx_op_t idx_op;
    logic        pos_load;
    efa_wr_sel_t wr_sel;
    efa_cnt_op_t cnt_op;
    logic        res_set;
    logic        res_hit;
    efa_status_t res_status;
    logic        out_load;
  } efa_cmd_t;

  typedef struct packed {
    efa_op_t op;
    logic    hit;
    logic    drop;
    logic    stop_insert;
    logic    below_first;
    logic    last;
    logic    past_end;
    logic    shu_more;
    logic    empty;
    logic    full;
  } efa_stat_t;

endpackage

`default_nettype wire

@@ rtl/efa_datapath.sv @@
// ----------------------------------------------------------------------------
// efa_datapath: extent table memory, index counters and compare logic
// one table read and one table write per cycle, read data registered
// ----------------------------------------------------------------------------
`default_nettype none

module efa_datapath #(
  parameter int TABLE_ENTRIES = efa_pkg::EFA_TABLE_ENTRIES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [1:0]                     in_operation,
  input  logic [efa_pkg::EFA_ADDR_W-1:0] in_start_block,
  input  logic [efa_pkg::EFA_ADDR_W-1:0] in_block_count,
  input  efa_pkg::efa_cmd_t              cmd,
  output efa_pkg::efa_stat_t             stat,
  output logic [efa_pkg::EFA_ADDR_W-1:0] out_result_block,
  output logic [efa_pkg::EFA_ADDR_W-1:0] out_taken_count,
  output logic [1:0]                     out_status
);
  import efa_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  efa_entry_t mem [TABLE_ENTRIES];
  efa_entry_t rdata_r;
  efa_entry_t wr_data;
  efa_entry_t upd_entry;
  logic       wr_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] rd_idx;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;

  efa_op_t               op_r;
  logic [EFA_ADDR_W-1:0] first_r, want_r, end_r;
  logic [EFA_ADDR_W-1:0] ent_end, amt;
  logic                  hit;

  logic [EFA_ADDR_W-1:0] res_block_r, res_taken_r;
  efa_status_t           res_status_r;
  logic [EFA_ADDR_W-1:0] out_block_r, out_taken_r;
  efa_status_t           out_status_r;

  // compare logic on the entry read last cycle
  always_comb begin
    ent_end = rdata_r.start + rdata_r.length;
    amt     = (op_r == OP_TAKE && want_r > rdata_r.length) ? rdata_r.length : want_r;
    case (op_r)
      OP_ALLOC: hit = (rdata_r.length >= want_r);
      OP_FREE:  hit = (rdata_r.start == end_r) || (ent_end == first_r);
      OP_TAKE:  hit = (rdata_r.start == first_r);
      default:  hit = 1'b0;
    endcase
  end

  always_comb begin
    stat.op          = op_r;
    stat.hit         = hit;
    stat.drop        = (rdata_r.length == amt);
    stat.stop_insert = (first_r < rdata_r.start);
    stat.below_first = (idx_r == '0) && (first_r < rdata_r.start);
    stat.last        = ((idx_r + CW'(1)) == count_r);
    stat.past_end    = (first_r >= ent_end);
    stat.shu_more    = (idx_r > pos_r);
    stat.empty       = (count_r == '0);
    stat.full        = (count_r == FULL_COUNT);
  end

  // new contents of a hit entry
  always_comb begin
    if (op_r == OP_FREE) begin
      upd_entry.start  = (rdata_r.start == end_r) ? first_r : rdata_r.start;
      upd_entry.length = rdata_r.length + want_r;
    end else begin
      upd_entry.start  = rdata_r.start + amt;
      upd_entry.length = rdata_r.length - amt;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO:      rd_idx = '0;
      RD_LAST:      rd_idx = count_r - CW'(1);
      RD_NEXT:      rd_idx = idx_r + CW'(1);
      RD_SKIP_UP:   rd_idx = idx_r + CW'(2);
      RD_SKIP_DOWN: rd_idx = idx_r - CW'(2);
      default:      rd_idx = '0;
    endcase
    rd_addr = rd_idx[AW-1:0];
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx_r[AW-1:0];
    wr_data = upd_entry;
    case (cmd.wr_sel)
      WR_UPDATE: wr_data = upd_entry;
      WR_SHIFT:  wr_data = rdata_r;
      WR_NEW: begin
        wr_addr       = pos_r[AW-1:0];
        wr_data.start  = first_r;
        wr_data.length = want_r;
      end
      default:   wr_en = 1'b0;
    endcase
  end

  always_comb begin
    if (cmd.start) begin
      idx_nxt = '0;
    end else begin
      case (cmd.idx_op)
        IDX_INC:   idx_nxt = idx_r + CW'(1);
        IDX_DEC:   idx_nxt = idx_r - CW'(1);
        IDX_COUNT: idx_nxt = count_r;
        default:   idx_nxt = idx_r;
      endcase
    end
    if (cmd.start) begin
      pos_nxt = count_r;
    end else if (cmd.pos_load) begin
      pos_nxt = idx_r;
    end else begin
      pos_nxt = pos_r;
    end
    case (cmd.cnt_op)
      CNT_INC: count_nxt = count_r + CW'(1);
      CNT_DEC: count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    if (cmd.start) begin
      op_r    <= efa_op_t'(in_operation);
      first_r <= in_start_block;
      want_r  <= in_block_count;
      end_r   <= in_start_block + in_block_count;
    end
    if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
      res_block_r  <= (cmd.res_hit && op_r == OP_ALLOC) ? rdata_r.start : '0;
      res_taken_r  <= (cmd.res_hit && op_r == OP_TAKE) ? amt : '0;
    end
    if (cmd.out_load) begin
      out_block_r  <= res_block_r;
      out_taken_r  <= res_taken_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_result_block = out_block_r;
  assign out_taken_count  = out_taken_r;
  assign out_status       = out_status_r;

endmodule

`default_nettype wire

@@ rtl/efa_ctrl.sv @@
// ----------------------------------------------------------------------------
// efa_ctrl: sequencer for the extent free-list allocator
// walks scan, shift and result phases and owns the result valid flag
// ----------------------------------------------------------------------------
`default_nettype none

module efa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  output logic               out_valid,
  input  logic               out_ready,
  input  efa_pkg::efa_stat_t stat,
  output efa_pkg::efa_cmd_t  cmd
);
  import efa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE_LAST,
    S_EVAL,
    S_INS_PREP,
    S_SHIFT_UP,
    S_SHIFT_DOWN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          case (efa_op_t'(in_operation))
            OP_ALLOC: begin
              if (stat.empty) begin
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_NOFIT;
                state_nxt      = S_DONE;
              end else begin
                cmd.rd_sel = RD_ZERO;
                state_nxt  = S_EVAL;
              end
            end
            OP_FREE: begin
              if (stat.empty) begin
                state_nxt = S_INS_PREP;
              end else begin
                cmd.rd_sel = RD_ZERO;
                state_nxt  = S_EVAL;
              end
            end
            OP_TAKE: begin
              if (stat.empty) begin
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_NOTFOUND;
                state_nxt      = S_DONE;
              end else begin
                cmd.rd_sel = RD_LAST;
                state_nxt  = S_TAKE_LAST;
              end
            end
            default: begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_OK;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end
      S_TAKE_LAST: begin
        if (stat.past_end) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_NOTFOUND;
          state_nxt      = S_DONE;
        end else begin
          cmd.rd_sel = RD_ZERO;
          state_nxt  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.rd_sel = RD_NEXT;
        case (stat.op)
          OP_ALLOC: begin
            if (stat.hit) begin
              cmd.res_set    = 1'b1;
              cmd.res_hit    = 1'b1;
              cmd.res_status = ST_OK;
              if (stat.drop) begin
                state_nxt = S_SHIFT_DOWN;
              end else begin
                cmd.wr_sel = WR_UPDATE;
                state_nxt  = S_DONE;
              end
            end else if (stat.last) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_NOFIT;
              state_nxt      = S_DONE;
            end else begin
              cmd.idx_op = IDX_INC;
            end
          end
          OP_FREE: begin
            if (stat.hit) begin
              cmd.wr_sel     = WR_UPDATE;
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_OK;
              state_nxt      = S_DONE;
            end else if (stat.stop_insert) begin
              cmd.pos_load = 1'b1;
              state_nxt    = S_INS_PREP;
            end else if (stat.last) begin
              state_nxt = S_INS_PREP;
            end else begin
              cmd.idx_op = IDX_INC;
            end
          end
          OP_TAKE: begin
            if (stat.below_first) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_NOTFOUND;
              state_nxt      = S_DONE;
            end else if (stat.hit) begin
              cmd.res_set    = 1'b1;
              cmd.res_hit    = 1'b1;
              cmd.res_status = ST_OK;
              if (stat.drop) begin
                state_nxt = S_SHIFT_DOWN;
              end else begin
                cmd.wr_sel = WR_UPDATE;
                state_nxt  = S_DONE;
              end
            end else if (stat.last) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_NOTFOUND;
              state_nxt      = S_DONE;
            end else begin
              cmd.idx_op = IDX_INC;
            end
          end
          default: begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_OK;
            state_nxt      = S_DONE;
          end
        endcase
      end
      S_INS_PREP: begin
        if (stat.full) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          cmd.rd_sel = RD_LAST;
          cmd.idx_op = IDX_COUNT;
          state_nxt  = S_SHIFT_UP;
        end
      end
      S_SHIFT_UP: begin
        if (stat.shu_more) begin
          cmd.wr_sel = WR_SHIFT;
          cmd.rd_sel = RD_SKIP_DOWN;
          cmd.idx_op = IDX_DEC;
        end else begin
          cmd.wr_sel     = WR_NEW;
          cmd.cnt_op     = CNT_INC;
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_OK;
          state_nxt      = S_DONE;
        end
      end
      S_SHIFT_DOWN: begin
        if (!stat.last) begin
          cmd.wr_sel = WR_SHIFT;
          cmd.rd_sel = RD_SKIP_UP;
          cmd.idx_op = IDX_INC;
        end else begin
          cmd.cnt_op = CNT_DEC;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ rtl/extent_free_list_allocator_core.sv @@
// ----------------------------------------------------------------------------
// extent_free_list_allocator_core: first-fit extent allocator with coalescing
// sorted table of free extents; allocate, free and take requests, one result
// per request
// ----------------------------------------------------------------------------
// sequence: an unused opcode or an empty-table miss goes straight from
//   acceptance to the result state; otherwise the table memory (one read and
//   one write port) is scanned one entry per cycle and then shifted one entry
//   per cycle
// throughput: one transaction at a time; the next one is taken while the
//   previous result still waits in the output register
// reset: extent count cleared, table contents left undefined (no clearing
//   pass), ready for a transaction as soon as reset is released
`default_nettype none

module extent_free_list_allocator_core #(
  parameter int TABLE_ENTRIES = efa_pkg::EFA_TABLE_ENTRIES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_operation,
  input  logic [efa_pkg::EFA_ADDR_W-1:0] in_start_block,
  input  logic [efa_pkg::EFA_ADDR_W-1:0] in_block_count,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [efa_pkg::EFA_ADDR_W-1:0] out_result_block,
  output logic [efa_pkg::EFA_ADDR_W-1:0] out_taken_count,
  output logic [1:0]                     out_status
);
  import efa_pkg::*;

  // command bundle from the sequencer, flags back from the datapath
  efa_cmd_t  cmd;
  efa_stat_t stat;

  // sequencer: scan, shift-up on insert, shift-down on removal, result hand-off
  efa_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // table memory, entry count, scan index and the result registers
  efa_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_operation     (in_operation),
    .in_start_block   (in_start_block),
    .in_block_count   (in_block_count),
    .cmd              (cmd),
    .stat             (stat),
    .out_result_block (out_result_block),
    .out_taken_count  (out_taken_count),
    .out_status       (out_status)
  );

`ifndef SYNTHESIS
  // an insert only happens with room left in the table
  a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_op == CNT_INC |-> !stat.full)
    else $error("entry count grows past table size");

  // a removal only happens with at least one entry
  a_dec_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_op == CNT_DEC |-> !stat.empty)
    else $error("entry count drops below zero");

  // writing the new extent always comes with the count increment
  a_new_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_sel == WR_NEW |-> cmd.cnt_op == CNT_INC)
    else $error("new extent written without count update");

  // a result is never loaded over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
